// ===== rtl/oltc_pkg.sv =====
// ----------------------------------------------------------------------------
// oltc_pkg
// Shared field widths, codes and controller/datapath bundles of the
// offset-to-line/column locator.
// ----------------------------------------------------------------------------
`default_nettype none

package oltc_pkg;

  localparam int MODE_W   = 2;
  localparam int FILE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int QOFF_W   = 20;
  localparam int STATUS_W = 2;
  localparam int LINE_W   = 13;
  localparam int COL_W    = 21;

  localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_LOCATE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FILE = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture request payload
    logic exec;      // decode, update tables, start search
    logic step;      // one search iteration
    logic fin_rd;    // read start of found line
    logic fin_calc;  // form line/column result
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic srch_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/oltc_in_if.sv =====
// ----------------------------------------------------------------------------
// oltc_in_if
// Request channel: valid/ready handshake with mode, file, byte and offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface oltc_in_if;
  logic                          valid;
  logic                          ready;
  logic [oltc_pkg::MODE_W-1:0]   mode;
  logic [oltc_pkg::FILE_W-1:0]   file_sel;
  logic [oltc_pkg::BYTE_W-1:0]   byte_value;
  logic [oltc_pkg::QOFF_W-1:0]   query_offset;

  modport source (
    output valid, mode, file_sel, byte_value, query_offset,
    input  ready
  );

  modport sink (
    input  valid, mode, file_sel, byte_value, query_offset,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/oltc_out_if.sv =====
// ----------------------------------------------------------------------------
// oltc_out_if
// Result channel: valid/ready handshake with status, file, line and column.
// ----------------------------------------------------------------------------
`default_nettype none

interface oltc_out_if;
  logic                            valid;
  logic                            ready;
  logic [oltc_pkg::STATUS_W-1:0]   status;
  logic [oltc_pkg::FILE_W-1:0]     file_out;
  logic [oltc_pkg::LINE_W-1:0]     line_number;
  logic [oltc_pkg::COL_W-1:0]      column_number;

  modport source (
    output valid, status, file_out, line_number, column_number,
    input  ready
  );

  modport sink (
    input  valid, status, file_out, line_number, column_number,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/oltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// oltc_ctrl
// Request sequencer: accept, execute, search loop, final read, result
// calculation and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oltc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire oltc_pkg::sts_t sts_i,
  output oltc_pkg::cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SRCH  = 6'b000100,
    S_FRD   = 6'b001000,
    S_FCALC = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_search ? S_SRCH : S_DONE;
      end
      S_SRCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.srch_done) begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = S_FCALC;
      end
      S_FCALC: begin
        cmd_o.fin_calc = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted request did not enter execute");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while stalled");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result valid raised outside hand-off");

endmodule

`default_nettype wire

// ===== rtl/oltc_dp.sv =====
// ----------------------------------------------------------------------------
// oltc_dp
// Datapath: line start memory, per-file counters, binary search registers
// and result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module oltc_dp #(
  parameter int MAX_FILES   = 4,
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire oltc_pkg::cmd_t                  cmd_i,
  output oltc_pkg::sts_t                       sts_o,
  input  wire logic [oltc_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [oltc_pkg::FILE_W-1:0]     file_sel_i,
  input  wire logic [oltc_pkg::BYTE_W-1:0]     byte_value_i,
  input  wire logic [oltc_pkg::QOFF_W-1:0]     query_offset_i,
  output logic [oltc_pkg::STATUS_W-1:0]        status_o,
  output logic [oltc_pkg::FILE_W-1:0]          file_out_o,
  output logic [oltc_pkg::LINE_W-1:0]          line_number_o,
  output logic [oltc_pkg::COL_W-1:0]           column_number_o
);

  localparam int OB    = OFFSET_BITS;
  localparam int DEPTH = MAX_FILES * MAX_LINES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int FOW   = $clog2(MAX_FILES + 1);
  localparam int LTW   = $clog2(MAX_LINES + 1);
  localparam int QW    = (OB > oltc_pkg::QOFF_W) ? OB : oltc_pkg::QOFF_W;
  localparam int CW    = (OB + 1 > oltc_pkg::COL_W) ? OB + 1 : oltc_pkg::COL_W;
  localparam int LWW   = (LTW > oltc_pkg::LINE_W) ? LTW : oltc_pkg::LINE_W;
  localparam int XW    = 8;

  // line start memory
  logic [OB-1:0] mem [DEPTH];
  logic [OB-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [OB-1:0] wdata;

  // captured request
  oltc_pkg::mode_e            mode_q;
  logic [oltc_pkg::FILE_W-1:0] sel_q;
  logic [oltc_pkg::BYTE_W-1:0] byte_q;
  logic [OB-1:0]              qoff_q;
  logic [QW-1:0]              qoff_ext;

  // per-file state
  logic [FOW-1:0] files_open_q;
  logic [LTW-1:0] line_total_q [MAX_FILES];
  logic [OB:0]    bytes_q      [MAX_FILES];

  // search
  logic [AW-1:0]  base_q;
  logic [LTW-1:0] lo_q, hi_q, mid_q;
  logic [LTW-1:0] lo_n, hi_n, mid_n;
  logic           rd_pend_q;
  logic           srch_done, issue;

  // execute decode
  logic [FOW-1:0] newest;
  logic [FW-1:0]  fidx, fopen;
  logic [XW-1:0]  sel_x, fo_x, nw_x;
  logic           sel_ok;
  logic [LTW-1:0] cur_total;
  logic [OB:0]    cur_bytes;
  logic [AW-1:0]  base_c;
  logic           open_do, app_do, nl_do, is_search;
  oltc_pkg::status_e           ex_status;
  logic [oltc_pkg::FILE_W-1:0] ex_file;

  // result
  logic [CW-1:0]                 col_w;
  logic [LWW-1:0]                line_w;
  oltc_pkg::status_e             res_status_q;
  logic [oltc_pkg::FILE_W-1:0]   res_file_q;
  logic [oltc_pkg::LINE_W-1:0]   res_line_q;
  logic [oltc_pkg::COL_W-1:0]    res_col_q;
  logic [oltc_pkg::STATUS_W-1:0] out_status_q;
  logic [oltc_pkg::FILE_W-1:0]   out_file_q;
  logic [oltc_pkg::LINE_W-1:0]   out_line_q;
  logic [oltc_pkg::COL_W-1:0]    out_col_q;

  assign qoff_ext = QW'(query_offset_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= oltc_pkg::mode_e'(mode_i);
      sel_q  <= file_sel_i;
      byte_q <= byte_value_i;
      qoff_q <= qoff_ext[OB-1:0];
    end
  end

  // ---- execute decode ----
  assign newest    = files_open_q - FOW'(1);
  assign sel_x     = XW'(sel_q);
  assign fo_x      = XW'(files_open_q);
  assign nw_x      = XW'(newest);
  assign sel_ok    = sel_x < fo_x;
  assign fopen     = files_open_q[FW-1:0];
  assign fidx      = (mode_q == oltc_pkg::MODE_LOCATE) ? sel_x[FW-1:0] : newest[FW-1:0];
  assign cur_total = line_total_q[fidx];
  assign cur_bytes = bytes_q[fidx];
  assign base_c    = AW'(int'(fidx) * MAX_LINES);

  always_comb begin
    ex_status = oltc_pkg::ST_OK;
    ex_file   = '0;
    open_do   = 1'b0;
    app_do    = 1'b0;
    nl_do     = 1'b0;
    is_search = 1'b0;
    mem_we    = 1'b0;
    waddr     = base_c + AW'(cur_total);
    wdata     = cur_bytes[OB-1:0] + OB'(1);
    unique case (mode_q)
      oltc_pkg::MODE_OPEN: begin
        if (files_open_q >= FOW'(MAX_FILES)) begin
          ex_status = oltc_pkg::ST_FULL;
        end else begin
          ex_file = fo_x[oltc_pkg::FILE_W-1:0];
          open_do = 1'b1;
          mem_we  = 1'b1;
          waddr   = AW'(int'(fopen) * MAX_LINES);
          wdata   = '0;
        end
      end
      oltc_pkg::MODE_APPEND: begin
        if (files_open_q == '0) begin
          ex_status = oltc_pkg::ST_NO_FILE;
        end else begin
          ex_file = nw_x[oltc_pkg::FILE_W-1:0];
          if (cur_bytes[OB]) begin
            ex_status = oltc_pkg::ST_FULL;
          end else if (byte_q == oltc_pkg::NL_BYTE && cur_bytes[OB-1:0] != '1) begin
            if (cur_total >= LTW'(MAX_LINES)) begin
              ex_status = oltc_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              nl_do  = 1'b1;
              app_do = 1'b1;
            end
          end else begin
            app_do = 1'b1;
          end
        end
      end
      oltc_pkg::MODE_LOCATE: begin
        ex_file = sel_q;
        if (!sel_ok) begin
          ex_status = oltc_pkg::ST_NO_FILE;
        end else begin
          is_search = 1'b1;
        end
      end
      oltc_pkg::MODE_NONE: begin
        ex_status = oltc_pkg::ST_OK;
      end
    endcase
    if (!cmd_i.exec) begin
      mem_we = 1'b0;
    end
  end

  // ---- search step ----
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rd_pend_q) begin
      if (rdata_q <= qoff_q) begin
        lo_n = mid_q + LTW'(1);
      end else begin
        hi_n = mid_q;
      end
    end
    mid_n     = lo_n + ((hi_n - lo_n) >> 1);
    srch_done = !(lo_n < hi_n);
    issue     = cmd_i.step && !srch_done;
  end

  assign mem_re = issue || cmd_i.fin_rd;
  assign raddr  = cmd_i.fin_rd ? base_q + AW'(lo_q - LTW'(1)) : base_q + AW'(mid_n);

  assign sts_o.is_search = is_search;
  assign sts_o.srch_done = srch_done;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // ---- file tables and search control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      files_open_q <= '0;
      rd_pend_q    <= 1'b0;
      for (int i = 0; i < MAX_FILES; i++) begin
        line_total_q[i] <= '0;
        bytes_q[i]      <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        rd_pend_q <= 1'b0;
        if (open_do) begin
          line_total_q[fopen] <= LTW'(1);
          bytes_q[fopen]      <= '0;
          files_open_q        <= files_open_q + FOW'(1);
        end
        if (app_do) begin
          bytes_q[fidx] <= cur_bytes + (OB+1)'(1);
        end
        if (nl_do) begin
          line_total_q[fidx] <= cur_total + LTW'(1);
        end
      end else if (cmd_i.step) begin
        rd_pend_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      base_q <= base_c;
      lo_q   <= '0;
      hi_q   <= cur_total;
    end else if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
    end
  end

  // ---- result ----
  assign col_w  = CW'(qoff_q) - CW'(rdata_q) + CW'(1);
  assign line_w = LWW'(lo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= ex_status;
      res_file_q   <= ex_file;
      res_line_q   <= '0;
      res_col_q    <= '0;
    end else if (cmd_i.fin_calc) begin
      res_status_q <= oltc_pkg::ST_OK;
      res_line_q   <= line_w[oltc_pkg::LINE_W-1:0];
      res_col_q    <= col_w[oltc_pkg::COL_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_file_q   <= res_file_q;
      out_line_q   <= res_line_q;
      out_col_q    <= res_col_q;
    end
  end

  assign status_o        = out_status_q;
  assign file_out_o      = out_file_q;
  assign line_number_o   = out_line_q;
  assign column_number_o = out_col_q;

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> lo_q <= hi_q)
    else $error("search bounds crossed");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_rd |-> lo_q != '0)
    else $error("located line is zero");

  a_files_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    files_open_q <= FOW'(MAX_FILES))
    else $error("open file count past limit");

endmodule

`default_nettype wire

// ===== rtl/offset_to_line_column_locator.sv =====
// ----------------------------------------------------------------------------
// offset_to_line_column_locator
// Line start tables for up to MAX_FILES files with offset-to-line/column
// lookup.
//
// Requests arrive on in_i (valid/ready); each yields exactly one result on
// out_o. Mode 0 opens the next file, mode 1 appends a byte to the newest
// file (a newline records the next line start), mode 2 locates an offset
// in a file by binary search over its line start memory.
// A locate does one memory read per search step on the single read port of
// the line start memory, then one read of the found line's start.
// The next request is taken in the cycle after a result moves to the output
// register; no request is taken while an earlier one is still in progress.
// A new request is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result waits internally and
// ready stays low until the output register frees up.
// Reset clears all file counters; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_to_line_column_locator #(
  parameter int MAX_FILES   = 4,
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oltc_in_if.sink    in_i,
  oltc_out_if.source out_o
);

  oltc_pkg::cmd_t cmd;
  oltc_pkg::sts_t sts;

  oltc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  oltc_dp #(
    .MAX_FILES   (MAX_FILES),
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .file_sel_i      (in_i.file_sel),
    .byte_value_i    (in_i.byte_value),
    .query_offset_i  (in_i.query_offset),
    .status_o        (out_o.status),
    .file_out_o      (out_o.file_out),
    .line_number_o   (out_o.line_number),
    .column_number_o (out_o.column_number)
  );

endmodule

`default_nettype wire
